[hw/rtl/assert_macros.svh]
// Assertion helpers: clocked on the rising edge, off while reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[hw/rtl/cgp_pkg.sv]
package cgp_pkg;

  localparam int MEMORY_BYTES  = 16384;
  localparam int ADDR_W        = $clog2(MEMORY_BYTES);
  localparam int ROW_BYTES     = 80;
  localparam int SCREEN_ROWS   = 200;
  localparam int ODD_BANK_BASE = 8192;
  localparam int GROUP_PIXELS  = 8;
  localparam int PIX_IDX_W     = $clog2(GROUP_PIXELS);

  localparam int MODE_ENABLE_BIT = 3;
  localparam int MODE_HIRES_BIT  = 4;
  localparam int CSEL_BRIGHT_BIT = 4;
  localparam int CSEL_PAL_BIT    = 5;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_RENDER = 1'b1
  } action_t;

  typedef enum logic {
    REG_MODE = 1'b0,
    REG_CSEL = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic       enable;
    logic       hires;
    logic       bright;
    logic       pal_one;
    logic [3:0] nib;
  } disp_cfg_t;

  typedef struct packed {
    logic              write;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic [7:0]        row;
    logic [6:0]        col;
  } front_item_t;

  function automatic logic [23:0] cga_rgb(input logic [3:0] c);
    logic [23:0] rgb;
    case (c)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'h0000AA;
      4'd2:    rgb = 24'h00AA00;
      4'd3:    rgb = 24'h00AAAA;
      4'd4:    rgb = 24'hAA0000;
      4'd5:    rgb = 24'hAA00AA;
      4'd6:    rgb = 24'hAA5500;
      4'd7:    rgb = 24'hAAAAAA;
      4'd8:    rgb = 24'h555555;
      4'd9:    rgb = 24'h5555FF;
      4'd10:   rgb = 24'h55FF55;
      4'd11:   rgb = 24'h55FFFF;
      4'd12:   rgb = 24'hFF5555;
      4'd13:   rgb = 24'hFF55FF;
      4'd14:   rgb = 24'hFFFF55;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

  // Palette zero gives 2v, palette one 2v+1, intensity adds 8.
  function automatic logic [3:0] pixel_colour(input disp_cfg_t cfg,
                                              input logic [7:0] pix_byte,
                                              input logic [PIX_IDX_W-1:0] idx);
    logic [1:0] pair;
    logic [2:0] shamt;
    logic [1:0] v;
    logic [3:0] c;
    pair  = idx[PIX_IDX_W-1:1];
    shamt = 3'd6 - {pair, 1'b0};
    v     = 2'((pix_byte >> shamt) & 8'd3);
    if (!cfg.enable) begin
      c = 4'd0;
    end else if (cfg.hires) begin
      c = pix_byte[3'd7 - idx] ? cfg.nib : 4'd0;
    end else if (v == 2'd0) begin
      c = cfg.nib;
    end else begin
      c = {cfg.bright, v, cfg.pal_one};
    end
    return c;
  endfunction

endpackage

[hw/rtl/cgp_front.sv]
module cgp_front
  import cgp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [13:0] in_memory_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_screen_row,
  input  logic [6:0]  in_byte_column,
  input  logic        down_ready,
  output logic        s1_valid,
  output front_item_t s1_item
);

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  front_item_t s1_item_r;
  front_item_t item_nxt;
  logic        is_write;
  logic        in_range;
  logic [6:0]  row_half;
  logic [ADDR_W-1:0] offset;

  assign is_write = (in_action == ACT_WRITE);
  assign in_range = (in_screen_row < 8'(SCREEN_ROWS)) && (in_byte_column < 7'(ROW_BYTES));
  assign row_half = in_screen_row[7:1];
  assign offset   = ADDR_W'(row_half) * ADDR_W'(ROW_BYTES) + ADDR_W'(in_byte_column);

  assign in_stall = s1_valid_r && !down_ready;

  always_comb begin
    item_nxt.write = is_write;
    item_nxt.data  = in_write_data;
    item_nxt.row   = in_screen_row;
    item_nxt.col   = in_byte_column;
    if (is_write) begin
      item_nxt.addr = ADDR_W'(in_memory_address);
    end else if (in_screen_row[0]) begin
      item_nxt.addr = offset + ADDR_W'(ODD_BANK_BASE);
    end else begin
      item_nxt.addr = offset;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid && (is_write || in_range);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= item_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

[hw/rtl/cgp_vram.sv]
module cgp_vram
  import cgp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s1_valid,
  input  front_item_t s1_item,
  output logic        up_ready,
  output logic        s2_valid,
  output logic [7:0]  s2_row,
  output logic [6:0]  s2_col,
  output logic [7:0]  s2_byte,
  input  logic        s2_take
);

  logic [7:0] vram_mem_r [MEMORY_BYTES];
  logic       s2_valid_r;
  logic       s2_valid_nxt;
  logic [7:0] s2_row_r;
  logic [6:0] s2_col_r;
  logic [7:0] rd_byte_r;
  logic       advance;

  assign up_ready = !s2_valid_r || s2_take;
  assign advance  = s1_valid && up_ready;

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (up_ready) begin
      s2_valid_nxt = s1_valid && !s1_item.write;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_item.write) begin
      vram_mem_r[s1_item.addr] <= s1_item.data;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !s1_item.write) begin
      rd_byte_r <= vram_mem_r[s1_item.addr];
      s2_row_r  <= s1_item.row;
      s2_col_r  <= s1_item.col;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_row   = s2_row_r;
  assign s2_col   = s2_col_r;
  assign s2_byte  = rd_byte_r;

endmodule

[hw/rtl/cgp_shifter.sv]
`include "assert_macros.svh"

module cgp_shifter
  import cgp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  disp_cfg_t   cfg,
  input  logic        s2_valid,
  input  logic [7:0]  s2_row,
  input  logic [6:0]  s2_col,
  input  logic [7:0]  s2_byte,
  output logic        s2_take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_pixel_x,
  output logic [7:0]  out_pixel_y,
  output logic [3:0]  out_colour_index,
  output logic [23:0] out_pixel_rgb,
  output logic        out_last_pixel
);

  logic                 ser_valid_r;
  logic                 ser_valid_nxt;
  logic [PIX_IDX_W-1:0] ser_cnt_r;
  logic [PIX_IDX_W-1:0] ser_cnt_nxt;
  logic [7:0]           ser_byte_r;
  logic [7:0]           ser_row_r;
  logic [6:0]           ser_col_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [9:0]           out_x_r;
  logic [7:0]           out_y_r;
  logic [3:0]           out_colour_r;
  logic [23:0]          out_rgb_r;
  logic                 out_last_r;
  logic                 out_free;
  logic                 step;
  logic                 last_step;
  logic [3:0]           colour;

  assign out_free  = !out_valid_r || !out_stall;
  assign step      = ser_valid_r && out_free;
  assign last_step = step && (ser_cnt_r == PIX_IDX_W'(GROUP_PIXELS - 1));
  assign s2_take   = s2_valid && (!ser_valid_r || last_step);
  assign colour    = pixel_colour(cfg, ser_byte_r, ser_cnt_r);

  always_comb begin
    ser_valid_nxt = ser_valid_r;
    ser_cnt_nxt   = ser_cnt_r;
    if (s2_take) begin
      ser_valid_nxt = 1'b1;
      ser_cnt_nxt   = '0;
    end else if (last_step) begin
      ser_valid_nxt = 1'b0;
      ser_cnt_nxt   = '0;
    end else if (step) begin
      ser_cnt_nxt = ser_cnt_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (step) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      ser_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ser_valid_r <= ser_valid_nxt;
      ser_cnt_r   <= ser_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      ser_byte_r <= s2_byte;
      ser_row_r  <= s2_row;
      ser_col_r  <= s2_col;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_x_r      <= {ser_col_r, ser_cnt_r};
      out_y_r      <= ser_row_r;
      out_colour_r <= colour;
      out_rgb_r    <= cga_rgb(colour);
      out_last_r   <= (ser_cnt_r == PIX_IDX_W'(GROUP_PIXELS - 1));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = out_x_r;
  assign out_pixel_y      = out_y_r;
  assign out_colour_index = out_colour_r;
  assign out_pixel_rgb    = out_rgb_r;
  assign out_last_pixel   = out_last_r;

  `ASSERT_IMPLIES(a_last_on_eighth, clk, rst_n, out_valid_r, out_last_r == (out_x_r[2:0] == 3'd7), "last flag off the eighth pixel")
  `ASSERT_NEXT(a_load_restarts, clk, rst_n, s2_take, ser_valid_r && ser_cnt_r == '0, "group load did not restart count")
  `ASSERT_NEXT(a_hold_count, clk, rst_n, ser_valid_r && !step && !s2_take, $stable(ser_cnt_r), "pixel count moved under stall")
  `ASSERT_IMPLIES(a_dark_when_off, clk, rst_n, out_valid_r && !cfg.enable, out_colour_r == 4'd0 && out_rgb_r == 24'd0, "pixel lit with display off")

endmodule

[hw/rtl/cga_graphics_pixel_generator.sv]
// CGA graphics-mode pixel generator with 16 KiB of video memory. A write item
// (action 0) stores one byte and produces no pixels; a render item (action 1)
// produces the eight pixels of one byte group, leftmost first, one per cycle
// while out_stall is low, with last_pixel on the eighth. Render items outside
// the 200x80 screen are dropped. Odd rows read the bank at 0x2000. Items flow
// through an input stage, a memory read stage and an eight-step pixel shifter
// with an output register, so a render item occupies the shifter for its eight
// pixels, and the shifter takes the next byte as its last pixel steps out; a
// write item ends at the memory stage. Reading a byte that was never written
// returns an unspecified value.
// Registers: 0x0 mode (0x08 display on, 0x10 high resolution), 0x4 colour
// select; change them only while no item is in flight.
`include "assert_macros.svh"

module cga_graphics_pixel_generator
  import cgp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [13:0] in_memory_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_screen_row,
  input  logic [6:0]  in_byte_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_pixel_x,
  output logic [7:0]  out_pixel_y,
  output logic [3:0]  out_colour_index,
  output logic [23:0] out_pixel_rgb,
  output logic        out_last_pixel,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic        [7:0] mode_r;
  logic        [7:0] mode_nxt;
  logic        [5:0] csel_r;
  logic        [5:0] csel_nxt;
  logic              cfg_write;
  reg_index_t        reg_sel;
  disp_cfg_t         disp_cfg;
  logic              s1_valid;
  front_item_t       s1_item;
  logic              vram_ready;
  logic              s2_valid;
  logic        [7:0] s2_row;
  logic        [6:0] s2_col;
  logic        [7:0] s2_byte;
  logic              s2_take;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = reg_index_t'(cfg_paddr[2]);

  always_comb begin
    mode_nxt = mode_r;
    csel_nxt = csel_r;
    if (cfg_write) begin
      case (reg_sel)
        REG_MODE: mode_nxt = cfg_pwdata[7:0];
        REG_CSEL: csel_nxt = cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MODE: cfg_prdata = {24'd0, mode_r};
      REG_CSEL: cfg_prdata = {26'd0, csel_r};
      default:  cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 8'd0;
      csel_r <= 6'd0;
    end else begin
      mode_r <= mode_nxt;
      csel_r <= csel_nxt;
    end
  end

  assign disp_cfg.enable  = mode_r[MODE_ENABLE_BIT];
  assign disp_cfg.hires   = mode_r[MODE_HIRES_BIT];
  assign disp_cfg.bright  = csel_r[CSEL_BRIGHT_BIT];
  assign disp_cfg.pal_one = csel_r[CSEL_PAL_BIT];
  assign disp_cfg.nib     = csel_r[3:0];

  cgp_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_memory_address (in_memory_address),
    .in_write_data     (in_write_data),
    .in_screen_row     (in_screen_row),
    .in_byte_column    (in_byte_column),
    .down_ready        (vram_ready),
    .s1_valid          (s1_valid),
    .s1_item           (s1_item)
  );

  cgp_vram u_vram (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .up_ready (vram_ready),
    .s2_valid (s2_valid),
    .s2_row   (s2_row),
    .s2_col   (s2_col),
    .s2_byte  (s2_byte),
    .s2_take  (s2_take)
  );

  cgp_shifter u_shifter (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (disp_cfg),
    .s2_valid         (s2_valid),
    .s2_row           (s2_row),
    .s2_col           (s2_col),
    .s2_byte          (s2_byte),
    .s2_take          (s2_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_colour_index (out_colour_index),
    .out_pixel_rgb    (out_pixel_rgb),
    .out_last_pixel   (out_last_pixel)
  );

  `ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, in_stall, s1_valid && s2_valid, "input stalled with free stages")
  `ASSERT_NEXT(a_cfg_write_lands, clk, rst_n, cfg_write && reg_sel == REG_MODE, mode_r == $past(cfg_pwdata[7:0]), "mode write lost")

endmodule

[test/tb.sv]
module tb;
  import cgp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int NUM_STEPS = 28;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 15;
  localparam int BANK_BYTES = SCREEN_ROWS / 2 * ROW_BYTES;

  localparam logic [16*24-1:0] CGA_RGB_TABLE = {
    24'hFFFFFF, 24'hFFFF55, 24'hFF55FF, 24'hFF5555,
    24'h55FFFF, 24'h55FF55, 24'h5555FF, 24'h555555,
    24'hAAAAAA, 24'hAA5500, 24'hAA00AA, 24'hAA0000,
    24'h00AAAA, 24'h00AA00, 24'h0000AA, 24'h000000
  };

  typedef enum logic {DO_ITEM, DO_CFG} step_kind_t;

  typedef struct packed {
    action_t     action;
    logic [13:0] addr;
    logic [7:0]  data;
    logic [7:0]  row;
    logic [6:0]  col;
  } vid_item_t;

  typedef struct packed {
    step_kind_t  kind;
    reg_index_t  regsel;
    logic [7:0]  value;
    action_t     action;
    logic [13:0] addr;
    logic [7:0]  data;
    logic [7:0]  row;
    logic [6:0]  col;
    logic        typed;
    logic [3:0]  colour;
    logic [23:0] rgb;
  } dir_step_t;

  typedef struct packed {
    logic [9:0]  x;
    logic [7:0]  y;
    logic [3:0]  colour;
    logic [23:0] rgb;
    logic        last;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [13:0] in_memory_address;
  logic [7:0]  in_write_data;
  logic [7:0]  in_screen_row;
  logic [6:0]  in_byte_column;
  logic        out_valid;
  logic        out_stall;
  logic [9:0]  out_pixel_x;
  logic [7:0]  out_pixel_y;
  logic [3:0]  out_colour_index;
  logic [23:0] out_pixel_rgb;
  logic        out_last_pixel;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  cga_graphics_pixel_generator u_top (.*);

  logic [7:0]  vram_shadow [MEMORY_BYTES];
  bit          vram_written [MEMORY_BYTES];
  logic [14:0] drawable_spots [$];
  pixel_t      expected_pixels [$];
  pixel_t      head_pixel;
  logic [7:0]  mode_shadow;
  logic [5:0]  csel_shadow;
  int          idle_pct;
  int          stall_pct;
  int          errors;
  int          cycle_count;

  int phase_idle_pct [NUM_PHASES] = '{0, 74, 0, 8, 0, 8};
  int phase_stall_pct [NUM_PHASES] = '{0, 0, 74, 8, 0, 8};
  int phase_mode [NUM_PHASES] = '{8'h08, 8'h18, 8'hEF, -1, 8'hFF, -1};
  int phase_csel [NUM_PHASES] = '{6'h00, 6'h3F, 6'h35, -1, -1, 6'h20};

  dir_step_t dir_table [NUM_STEPS] = '{
    '{DO_ITEM, REG_MODE, 8'h00, ACT_WRITE, 14'h0000, 8'hFF, 8'd0, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_WRITE, 14'h3F3F, 8'h1B, 8'd0, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_WRITE, 14'h3FFF, 8'hA5, 8'd0, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_WRITE, 14'h004F, 8'h00, 8'd0, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_WRITE, 14'h2000, 8'hE4, 8'd0, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_RENDER, 14'h3FFF, 8'hFF, 8'd0, 7'd0, 1'b1, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_RENDER, 14'h0000, 8'h00, 8'd199, 7'd79, 1'b1, 4'd0,
      24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_RENDER, 14'h0000, 8'h00, 8'd200, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_RENDER, 14'h0000, 8'h00, 8'd0, 7'd80, 1'b0, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_RENDER, 14'h0000, 8'h00, 8'd255, 7'd127, 1'b0, 4'd0,
      24'h0},
    '{DO_CFG, REG_MODE, 8'h18, ACT_WRITE, 14'h0000, 8'h00, 8'd0, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_CFG, REG_CSEL, 8'h0F, ACT_WRITE, 14'h0000, 8'h00, 8'd0, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_RENDER, 14'h0000, 8'h00, 8'd0, 7'd0, 1'b1, 4'd15,
      24'hFFFFFF},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_RENDER, 14'h0000, 8'h00, 8'd0, 7'd79, 1'b1, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_RENDER, 14'h0000, 8'h00, 8'd1, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_CFG, REG_CSEL, 8'h00, ACT_WRITE, 14'h0000, 8'h00, 8'd0, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_RENDER, 14'h0000, 8'h00, 8'd199, 7'd79, 1'b1, 4'd0,
      24'h0},
    '{DO_CFG, REG_MODE, 8'h08, ACT_WRITE, 14'h0000, 8'h00, 8'd0, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_RENDER, 14'h0000, 8'h00, 8'd1, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_CFG, REG_CSEL, 8'h3F, ACT_WRITE, 14'h0000, 8'h00, 8'd0, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_RENDER, 14'h0000, 8'h00, 8'd1, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_RENDER, 14'h0000, 8'h00, 8'd199, 7'd79, 1'b0, 4'd0,
      24'h0},
    '{DO_CFG, REG_CSEL, 8'h29, ACT_WRITE, 14'h0000, 8'h00, 8'd0, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_RENDER, 14'h0000, 8'h00, 8'd0, 7'd79, 1'b1, 4'd9,
      24'h5555FF},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_WRITE, 14'h0000, 8'h55, 8'd0, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_RENDER, 14'h0000, 8'h00, 8'd0, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_CFG, REG_MODE, 8'hF7, ACT_WRITE, 14'h0000, 8'h00, 8'd0, 7'd0, 1'b0, 4'd0, 24'h0},
    '{DO_ITEM, REG_MODE, 8'h00, ACT_RENDER, 14'h0000, 8'h00, 8'd1, 7'd0, 1'b1, 4'd0, 24'h0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("cga_graphics_pixel_generator test failed");
    $finish;
  end

  function automatic int vram_index(input logic [7:0] row, input logic [6:0] col);
    return (row[0] ? ODD_BANK_BASE : 0) + int'(row >> 1) * ROW_BYTES + int'(col);
  endfunction

  function automatic logic [3:0] predict_colour(input logic [7:0] pix_byte, input int i);
    logic [1:0] v;
    logic [3:0] c;
    v = 2'(pix_byte >> (6 - 2 * (i / 2)));
    if (!mode_shadow[MODE_ENABLE_BIT]) begin
      c = 4'd0;
    end else if (mode_shadow[MODE_HIRES_BIT]) begin
      c = pix_byte[7 - i] ? csel_shadow[3:0] : 4'd0;
    end else if (v == 2'd0) begin
      c = csel_shadow[3:0];
    end else begin
      case (v)
        2'd1: c = 4'd2;
        2'd2: c = 4'd4;
        default: c = 4'd6;
      endcase
      if (csel_shadow[CSEL_PAL_BIT]) c = c + 4'd1;
      if (csel_shadow[CSEL_BRIGHT_BIT]) c = c + 4'd8;
    end
    return c;
  endfunction

  task automatic expect_group(input logic [7:0] row, input logic [6:0] col, input logic typed,
                              input logic [3:0] tcol, input logic [23:0] trgb);
    pixel_t px;
    logic [7:0] pix_byte;
    pix_byte = vram_shadow[vram_index(row, col)];
    for (int i = 0; i < 8; i++) begin
      px.x = 10'(int'(col) * 8 + i);
      px.y = row;
      px.colour = typed ? tcol : predict_colour(pix_byte, i);
      px.rgb = typed ? trgb : CGA_RGB_TABLE[px.colour * 24 +: 24];
      px.last = (i == 7);
      expected_pixels.push_back(px);
    end
  endtask

  task automatic send_item(input vid_item_t it, input logic typed, input logic [3:0] tcol,
                           input logic [23:0] trgb);
    int off;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= it.action;
    in_memory_address <= it.addr;
    in_write_data <= it.data;
    in_screen_row <= it.row;
    in_byte_column <= it.col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.action == ACT_WRITE) begin
      vram_shadow[it.addr] = it.data;
      if (!vram_written[it.addr]) begin
        vram_written[it.addr] = 1'b1;
        off = int'(it.addr[12:0]);
        if (off < BANK_BYTES)
          drawable_spots.push_back({8'(2 * (off / ROW_BYTES) + it.addr[13]), 7'(off % ROW_BYTES)});
      end
    end else if (it.row < SCREEN_ROWS && it.col < ROW_BYTES) begin
      expect_group(it.row, it.col, typed, tcol, trgb);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [7:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_MODE) mode_shadow = value;
    else csel_shadow = value[5:0];
    @(posedge clk);
  endtask

  task automatic make_random_item(output vid_item_t it, output bit counts);
    int pick;
    logic [14:0] spot;
    it.action = ACT_WRITE;
    it.addr = 14'($urandom_range(MEMORY_BYTES - 1));
    it.data = 8'($urandom);
    it.row = 8'($urandom);
    it.col = 7'($urandom);
    counts = 1'b1;
    pick = $urandom_range(99);
    if (pick < 15) begin
      it.action = ACT_RENDER;
      counts = 1'b0;
      if (pick < 8) it.row = 8'($urandom_range(255, SCREEN_ROWS));
      else it.col = 7'($urandom_range(127, ROW_BYTES));
    end else if (pick < 55 || drawable_spots.size() == 0) begin
      if ($urandom_range(9) < 7)
        it.addr = 14'(($urandom_range(1) ? ODD_BANK_BASE : 0) + $urandom_range(BANK_BYTES - 1));
    end else begin
      spot = drawable_spots[$urandom_range(drawable_spots.size() - 1)];
      it.action = ACT_RENDER;
      it.row = spot[14:7];
      it.col = spot[6:0];
    end
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel with no item pending: x %0d y %0d", out_pixel_x, out_pixel_y);
        errors++;
      end else begin
        head_pixel = expected_pixels.pop_front();
        if (out_pixel_x !== head_pixel.x) begin
          $error("pixel_x expected %0d got %0d", head_pixel.x, out_pixel_x);
          errors++;
        end
        if (out_pixel_y !== head_pixel.y) begin
          $error("pixel_y expected %0d got %0d", head_pixel.y, out_pixel_y);
          errors++;
        end
        if (out_colour_index !== head_pixel.colour) begin
          $error("colour_index expected %0d got %0d", head_pixel.colour, out_colour_index);
          errors++;
        end
        if (out_pixel_rgb !== head_pixel.rgb) begin
          $error("pixel_rgb expected %06h got %06h", head_pixel.rgb, out_pixel_rgb);
          errors++;
        end
        if (out_last_pixel !== head_pixel.last) begin
          $error("last_pixel expected %0d got %0d", head_pixel.last, out_last_pixel);
          errors++;
        end
      end
    end
  end

  initial begin
    vid_item_t it;
    bit counts;
    int counted;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    mode_shadow = 8'h00;
    csel_shadow = 6'h00;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_WRITE;
    in_memory_address <= '0;
    in_write_data <= '0;
    in_screen_row <= '0;
    in_byte_column <= '0;
    out_stall <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int s = 0; s < NUM_STEPS; s++) begin
      if (dir_table[s].kind == DO_CFG) begin
        wait_drained();
        write_register(dir_table[s].regsel, dir_table[s].value);
      end else begin
        it.action = dir_table[s].action;
        it.addr = dir_table[s].addr;
        it.data = dir_table[s].data;
        it.row = dir_table[s].row;
        it.col = dir_table[s].col;
        send_item(it, dir_table[s].typed, dir_table[s].colour, dir_table[s].rgb);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      write_register(REG_MODE,
                     phase_mode[ph] < 0 ? 8'($urandom) : 8'(phase_mode[ph]));
      write_register(REG_CSEL,
                     phase_csel[ph] < 0 ? 8'($urandom_range(63)) : 8'(phase_csel[ph]));
      idle_pct = phase_idle_pct[ph];
      stall_pct = phase_stall_pct[ph];
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        make_random_item(it, counts);
        send_item(it, 1'b0, 4'd0, 24'h0);
        if (counts) counted++;
        if (ph == 1 && counted == ITEMS_PER_PHASE / 2) wait_drained();
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("cga_graphics_pixel_generator test passed");
    end else begin
      $display("cga_graphics_pixel_generator test failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/cgp_pkg.sv
hw/rtl/cgp_front.sv
hw/rtl/cgp_vram.sv
hw/rtl/cgp_shifter.sv
hw/rtl/cga_graphics_pixel_generator.sv
test/tb.sv
